[rtl/scfl_pkg.sv]
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types, constants and helpers for the size class free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scfl_pkg;

  // Sizing of the allocator.
  localparam int NUM_BUCKETS   = 24;
  localparam int DESC_DEPTH    = 1024;
  localparam int BATCH_COUNT   = 32;

  // Derived widths.
  localparam int DESC_AW       = $clog2(DESC_DEPTH);
  localparam int TOP_W         = DESC_AW + 1;
  localparam int CLS_W         = 5;
  localparam int CNT_W         = $clog2(BATCH_COUNT + 1);
  localparam int CSIZE_W       = NUM_BUCKETS + 2;
  localparam int TOTAL_W       = CSIZE_W + CNT_W;
  localparam int SUM_W         = ((TOTAL_W > 32) ? TOTAL_W : 32) + 1;
  localparam int PROD_W        = 42;
  localparam int MIN_CLASS     = 2;
  localparam int SMALL_CLASSES = 10;
  localparam int QUEUE_DEPTH   = 2;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_CALLOC  = 2'd1,
    KIND_REALLOC = 2'd2,
    KIND_FREE    = 2'd3
  } kind_t;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OOM    = 3'd1;
  localparam logic [2:0] ST_DOUBLE = 3'd2;
  localparam logic [2:0] ST_BADH   = 3'd3;
  localparam logic [2:0] ST_LARGE  = 3'd4;

  // Configuration register indexes.
  localparam logic REG_CHUNK_OVERHEAD = 1'b0;
  localparam logic REG_HEAP_LIMIT     = 1'b1;

  // Request transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [25:0] request_size;
    logic [15:0] element_count;
    logic [9:0]  handle;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  result_handle;
    logic [31:0] body_address;
    logic [4:0]  size_class;
    logic        moved;
    logic [25:0] copy_length;
    logic        zero_fill;
  } rsp_t;

  // Classified operation handed from the front end to the back end.
  typedef struct packed {
    kind_t             kind;
    logic              too_large;
    logic [CLS_W-1:0]  cls;
    logic [25:0]       size;
    logic [9:0]        handle;
  } op_t;

  // One chunk descriptor as stored in memory.
  typedef struct packed {
    logic [DESC_AW-1:0] next;
    logic [CLS_W-1:0]   cls;
    logic               live;
    logic [25:0]        size;
    logic [31:0]        base;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // Configuration register values.
  typedef struct packed {
    logic [6:0]  chunk_overhead;
    logic [31:0] heap_limit;
  } cfg_t;

  // Number of chunks carved in one refill of a class.
  function automatic logic [CNT_W-1:0] batch_count(input logic [CLS_W-1:0] b);
    int c;
    c = BATCH_COUNT - ((int'(b) < SMALL_CLASSES) ? 0 : int'(b));
    if (c < 1) begin
      c = 1;
    end
    return CNT_W'(c);
  endfunction

endpackage

`default_nettype wire

[rtl/scfl_ram.sv]
// ----------------------------------------------------------------------------
// scfl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/scfl_front.sv]
// ----------------------------------------------------------------------------
// scfl_front
// Accepts request transactions, forms the request size and picks the class.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire scfl_pkg::req_t req,
  input  wire logic          q_full,
  output logic               push,
  output scfl_pkg::op_t      push_data
);

  logic                         st_valid;
  scfl_pkg::kind_t              st_kind;
  logic [scfl_pkg::PROD_W-1:0]  st_size;
  logic [9:0]                   st_handle;
  logic [scfl_pkg::PROD_W-1:0]  prod;
  logic [scfl_pkg::CLS_W-1:0]   cls;
  logic                         too_large;

  // The stage holds while the queue is full.
  assign req_stall = st_valid & q_full;
  assign push      = st_valid & ~q_full;

  // Calloc sizes are the product of element size and count.
  assign prod = (scfl_pkg::kind_t'(req.kind) == scfl_pkg::KIND_CALLOC) ?
                scfl_pkg::PROD_W'(req.request_size) * scfl_pkg::PROD_W'(req.element_count) :
                scfl_pkg::PROD_W'(req.request_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (!req_stall) begin
      st_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      st_kind   <= scfl_pkg::kind_t'(req.kind);
      st_size   <= prod;
      st_handle <= req.handle;
    end
  end

  // Smallest class whose body holds the size.
  always_comb begin
    too_large = st_size > (scfl_pkg::PROD_W'(1) << scfl_pkg::NUM_BUCKETS);
    cls = scfl_pkg::CLS_W'(scfl_pkg::NUM_BUCKETS - 1);
    for (int b = scfl_pkg::NUM_BUCKETS - 2; b >= scfl_pkg::MIN_CLASS; b--) begin
      if (st_size <= (scfl_pkg::PROD_W'(1) << (b + 1))) begin
        cls = scfl_pkg::CLS_W'(b);
      end
    end
  end

  always_comb begin
    push_data.kind      = st_kind;
    push_data.too_large = too_large;
    push_data.cls       = cls;
    push_data.size      = st_size[25:0];
    push_data.handle    = st_handle;
  end

endmodule

`default_nettype wire

[rtl/scfl_queue.sv]
// ----------------------------------------------------------------------------
// scfl_queue
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire scfl_pkg::op_t push_data,
  input  wire logic          pop,
  output scfl_pkg::op_t      pop_data,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = $clog2(scfl_pkg::QUEUE_DEPTH);

  scfl_pkg::op_t      slots [scfl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full     = (count == (PTR_W + 1)'(scfl_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/scfl_back.sv]
// ----------------------------------------------------------------------------
// scfl_back
// Carries out operations on the free lists, refills classes from the pool
// and holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scfl_pkg::cfg_t cfg,
  input  wire logic          q_empty,
  input  wire scfl_pkg::op_t q_data,
  output logic               q_pop,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output scfl_pkg::rsp_t     rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_HCHK, S_GRAB, S_RMUL, S_RCHK, S_CARVE, S_POP, S_REL, S_RESP
  } state_t;

  localparam int AW = scfl_pkg::DESC_AW;

  state_t                          state;
  scfl_pkg::op_t                   op;
  scfl_pkg::desc_t                 oent;
  logic                            moving;
  logic [scfl_pkg::TOP_W-1:0]      desc_top;
  logic [31:0]                     pool_top;
  logic [AW-1:0]                   bucket_head [scfl_pkg::NUM_BUCKETS];
  logic [scfl_pkg::NUM_BUCKETS-1:0] head_valid;
  logic [scfl_pkg::CNT_W-1:0]      n_cnt;
  logic [scfl_pkg::CNT_W-1:0]      carve_i;
  logic [scfl_pkg::CSIZE_W-1:0]    csize;
  logic [scfl_pkg::TOTAL_W-1:0]    total;
  logic [31:0]                     carve_base;
  scfl_pkg::rsp_t                  res;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  scfl_pkg::desc_t                 ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [scfl_pkg::DESC_W-1:0]     ram_rdata;
  scfl_pkg::desc_t                 ent;
  logic                            rsp_take;
  logic [AW-1:0]                   carve_d;
  logic                            carve_last;
  logic [AW-1:0]                   op_head;
  logic                            op_hv;
  logic [AW-1:0]                   ent_head;
  logic                            ent_hv;
  logic [AW-1:0]                   old_head;
  logic                            old_hv;

  // Response that carries only an error status.
  function automatic scfl_pkg::rsp_t err_rsp(input logic [2:0] st);
    scfl_pkg::rsp_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  assign ent      = scfl_pkg::desc_t'(ram_rdata);
  assign rsp_take = rsp_valid & ~rsp_stall;
  assign q_pop    = (state == S_IDLE) & ~q_empty;

  assign op_head  = bucket_head[op.cls];
  assign op_hv    = head_valid[op.cls];
  assign ent_head = bucket_head[ent.cls];
  assign ent_hv   = head_valid[ent.cls];
  assign old_head = bucket_head[oent.cls];
  assign old_hv   = head_valid[oent.cls];

  assign carve_d    = desc_top[AW-1:0] + AW'(carve_i);
  assign carve_last = (carve_i == scfl_pkg::CNT_W'(n_cnt - 1'b1));

  scfl_ram #(
    .WIDTH (scfl_pkg::DESC_W),
    .DEPTH (scfl_pkg::DESC_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Descriptor memory accesses for each step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op.handle[AW-1:0];
    ram_wdata = ent;
    ram_raddr = op.handle[AW-1:0];
    case (state)
      S_HCHK: begin
        if (ent.live && op.kind == scfl_pkg::KIND_FREE) begin
          ram_we         = 1'b1;
          ram_wdata.next = ent_hv ? ent_head : op.handle[AW-1:0];
          ram_wdata.live = 1'b0;
        end else if (ent.live && !op.too_large && op.cls <= ent.cls) begin
          ram_we         = 1'b1;
          ram_wdata.size = op.size;
        end
      end
      S_GRAB: begin
        ram_raddr = op_head;
      end
      S_CARVE: begin
        ram_we         = 1'b1;
        ram_waddr      = carve_d;
        ram_wdata.next = carve_last ? carve_d : carve_d + 1'b1;
        ram_wdata.cls  = op.cls;
        ram_wdata.live = 1'b0;
        ram_wdata.size = '0;
        ram_wdata.base = carve_base;
      end
      S_POP: begin
        ram_we         = 1'b1;
        ram_waddr      = op_head;
        ram_wdata.live = 1'b1;
        ram_wdata.size = op.size;
      end
      S_REL: begin
        ram_we         = 1'b1;
        ram_wdata      = oent;
        ram_wdata.next = old_hv ? old_head : op.handle[AW-1:0];
        ram_wdata.live = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, list heads, pool state and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      desc_top   <= '0;
      pool_top   <= '0;
      head_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // A taken response clears unless a new one loads in the same cycle.
      if (rsp_take && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op     <= q_data;
            moving <= 1'b0;
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          if (op.kind == scfl_pkg::KIND_ALLOC || op.kind == scfl_pkg::KIND_CALLOC) begin
            if (op.too_large) begin
              res   <= err_rsp(scfl_pkg::ST_LARGE);
              state <= S_RESP;
            end else begin
              res   <= '0;
              state <= S_GRAB;
            end
          end else if (scfl_pkg::TOP_W'(op.handle) >= desc_top) begin
            res   <= err_rsp(scfl_pkg::ST_BADH);
            state <= S_RESP;
          end else begin
            res   <= '0;
            state <= S_HCHK;
          end
        end
        S_HCHK: begin
          if (!ent.live) begin
            res.status <= scfl_pkg::ST_DOUBLE;
            state      <= S_RESP;
          end else if (op.kind == scfl_pkg::KIND_FREE) begin
            res.result_handle      <= op.handle;
            res.body_address       <= ent.base;
            res.size_class         <= ent.cls;
            bucket_head[ent.cls]   <= op.handle[AW-1:0];
            head_valid[ent.cls]    <= 1'b1;
            state                  <= S_RESP;
          end else if (op.too_large) begin
            res.status <= scfl_pkg::ST_LARGE;
            state      <= S_RESP;
          end else if (op.cls <= ent.cls) begin
            res.result_handle <= op.handle;
            res.body_address  <= ent.base;
            res.size_class    <= ent.cls;
            state             <= S_RESP;
          end else begin
            oent   <= ent;
            moving <= 1'b1;
            state  <= S_GRAB;
          end
        end
        S_GRAB: begin
          if (op_hv) begin
            state <= S_POP;
          end else begin
            n_cnt <= scfl_pkg::batch_count(op.cls);
            csize <= (scfl_pkg::CSIZE_W'(1) << (op.cls + 1'b1)) +
                     scfl_pkg::CSIZE_W'(cfg.chunk_overhead);
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          total <= scfl_pkg::TOTAL_W'(n_cnt) * scfl_pkg::TOTAL_W'(csize);
          state <= S_RCHK;
        end
        S_RCHK: begin
          // Refill must fit both the descriptor store and the heap limit.
          if ((scfl_pkg::TOP_W + 1)'(desc_top) + (scfl_pkg::TOP_W + 1)'(n_cnt) >
              (scfl_pkg::TOP_W + 1)'(scfl_pkg::DESC_DEPTH) ||
              scfl_pkg::SUM_W'(pool_top) + scfl_pkg::SUM_W'(total) >
              scfl_pkg::SUM_W'(cfg.heap_limit)) begin
            res   <= err_rsp(scfl_pkg::ST_OOM);
            state <= S_RESP;
          end else begin
            carve_i    <= '0;
            carve_base <= pool_top;
            state      <= S_CARVE;
          end
        end
        S_CARVE: begin
          carve_i    <= carve_i + 1'b1;
          carve_base <= carve_base + 32'(csize);
          if (carve_last) begin
            bucket_head[op.cls] <= desc_top[AW-1:0];
            head_valid[op.cls]  <= 1'b1;
            desc_top            <= desc_top + scfl_pkg::TOP_W'(n_cnt);
            pool_top            <= pool_top + total[31:0];
            state               <= S_GRAB;
          end
        end
        S_POP: begin
          if (ent.next == op_head) begin
            head_valid[op.cls] <= 1'b0;
          end else begin
            bucket_head[op.cls] <= ent.next;
          end
          res.status        <= scfl_pkg::ST_OK;
          res.result_handle <= 10'(op_head);
          res.body_address  <= ent.base;
          res.size_class    <= op.cls;
          res.zero_fill     <= (op.kind == scfl_pkg::KIND_CALLOC);
          res.moved         <= moving;
          if (moving) begin
            res.copy_length <= (oent.size < op.size) ? oent.size : op.size;
            state           <= S_REL;
          end else begin
            res.copy_length <= '0;
            state           <= S_RESP;
          end
        end
        S_REL: begin
          bucket_head[oent.cls] <= op.handle[AW-1:0];
          head_valid[oent.cls]  <= 1'b1;
          state                 <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp_take) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/size_class_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top
// Power-of-two size class allocator with per-class free lists and a bump
// pool refill, plus its configuration registers.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall | scfl_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_stall | scfl_pkg::rsp_t
//   apb     | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// A transaction passes the front stage and the queue; the sequencer then steps
// through S_IDLE, S_DISP, S_GRAB, S_POP and S_RESP for an alloc, through S_IDLE,
// S_DISP, S_HCHK and S_RESP for a free or an in-place realloc, and adds S_GRAB,
// S_POP and S_REL before S_RESP for a moving realloc. A refill of an empty class
// runs S_RMUL, S_RCHK and one S_CARVE per chunk through the single RAM write port.
// Reset is synchronous; it empties all lists and the pool, with no clearing pass.
// The front end and its two-entry queue accept while a response waits, until full.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_list_allocator_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire scfl_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output scfl_pkg::rsp_t      rsp,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  scfl_pkg::cfg_t cfg;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  scfl_pkg::op_t  push_data;
  scfl_pkg::op_t  pop_data;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_overhead <= 7'd24;
      cfg.heap_limit     <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == scfl_pkg::REG_HEAP_LIMIT) begin
        cfg.heap_limit <= pwdata;
      end else begin
        cfg.chunk_overhead <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == scfl_pkg::REG_CHUNK_OVERHEAD) ?
                  {25'd0, cfg.chunk_overhead} : cfg.heap_limit;

  scfl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (push_data)
  );

  scfl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  scfl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[tb/scfl_checker.sv]
// ----------------------------------------------------------------------------
// scfl_checker
// Watches the request, response and configuration ports of the allocator.
// It keeps its own model of the free lists and the pool, predicts one
// response per accepted request, and compares each accepted response with
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_checker
  import scfl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_stall,
  input  wire req_t        req,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_stall,
  input  wire rsp_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               pending,
  output int               fail_count
);

  // Model copy of the configuration registers.
  logic [6:0]  overhead_m;
  logic [31:0] limit_m;

  // Model copy of the free lists, descriptors and pool.
  logic [9:0]  head_m [NUM_BUCKETS];
  logic        head_ok_m [NUM_BUCKETS];
  logic [9:0]  next_m [DESC_DEPTH];
  logic [4:0]  cls_m [DESC_DEPTH];
  logic        live_m [DESC_DEPTH];
  logic [25:0] size_m [DESC_DEPTH];
  logic [31:0] base_m [DESC_DEPTH];
  int unsigned desc_top_m;
  logic [31:0] pool_top_m;

  // Predicted responses, oldest first.
  rsp_t want_q [$];

  assign pending = want_q.size();

  // Smallest class that holds the size, NUM_BUCKETS when too large.
  function automatic int size_class_for(input logic [47:0] size);
    int b;
    b = MIN_CLASS;
    while (b < NUM_BUCKETS && size > (48'd1 << (b + 1))) begin
      b++;
    end
    return b;
  endfunction

  // Carve a batch of chunks for class b from the pool.
  function automatic bit carve_batch(input int b);
    int          cnt;
    logic [63:0] csize;
    logic [63:0] n;
    cnt = BATCH_COUNT - ((b < SMALL_CLASSES) ? 0 : b);
    if (cnt < 1) begin
      cnt = 1;
    end
    n = 64'(cnt);
    csize = (64'd1 << (b + 1)) + 64'(overhead_m);
    if (64'(desc_top_m) + n > 64'(DESC_DEPTH)) begin
      return 0;
    end
    if (64'(pool_top_m) + n * csize > 64'(limit_m)) begin
      return 0;
    end
    for (int i = 0; i < cnt; i++) begin
      next_m[desc_top_m + i] = (i + 1 < cnt) ? 10'(desc_top_m + i + 1) : 10'(desc_top_m + i);
      cls_m[desc_top_m + i]  = 5'(b);
      live_m[desc_top_m + i] = 1'b0;
      size_m[desc_top_m + i] = '0;
      base_m[desc_top_m + i] = 32'(64'(pool_top_m) + 64'(i) * csize);
    end
    head_m[b] = 10'(desc_top_m);
    head_ok_m[b] = 1'b1;
    desc_top_m += 32'(cnt);
    pool_top_m = 32'(64'(pool_top_m) + n * csize);
    return 1;
  endfunction

  // Pop a chunk of class b, refilling the list when empty.
  function automatic bit take_chunk(input int b, input logic [25:0] size,
                                    output logic [9:0] d);
    d = '0;
    if (!head_ok_m[b] && !carve_batch(b)) begin
      return 0;
    end
    d = head_m[b];
    if (next_m[d] == d) begin
      head_ok_m[b] = 1'b0;
    end else begin
      head_m[b] = next_m[d];
    end
    live_m[d] = 1'b1;
    size_m[d] = size;
    return 1;
  endfunction

  // Push a chunk back on its class list.
  function automatic void give_back(input logic [9:0] d);
    int b;
    b = int'(cls_m[d]);
    next_m[d] = head_ok_m[b] ? head_m[b] : d;
    head_m[b] = d;
    head_ok_m[b] = 1'b1;
    live_m[d] = 1'b0;
  endfunction

  // Expected response for one request; updates the model state.
  function automatic rsp_t alloc_response(input req_t r);
    rsp_t        o;
    logic [47:0] size;
    logic [9:0]  d;
    logic [25:0] osz;
    int          b;
    int          ob;
    o = '0;
    o.status = ST_OK;
    if (r.kind == KIND_ALLOC || r.kind == KIND_CALLOC) begin
      size = (r.kind == KIND_CALLOC) ? 48'(r.request_size) * 48'(r.element_count)
                                     : 48'(r.request_size);
      b = size_class_for(size);
      if (b >= NUM_BUCKETS) begin
        o.status = ST_LARGE;
      end else if (!take_chunk(b, 26'(size), d)) begin
        o.status = ST_OOM;
      end else begin
        o.result_handle = d;
        o.body_address = base_m[d];
        o.size_class = 5'(b);
        o.zero_fill = (r.kind == KIND_CALLOC);
      end
    end else if (32'(r.handle) >= desc_top_m) begin
      o.status = ST_BADH;
    end else if (!live_m[r.handle]) begin
      o.status = ST_DOUBLE;
    end else if (r.kind == KIND_FREE) begin
      o.result_handle = r.handle;
      o.body_address = base_m[r.handle];
      o.size_class = cls_m[r.handle];
      give_back(r.handle);
    end else begin
      b = size_class_for(48'(r.request_size));
      ob = int'(cls_m[r.handle]);
      if (b >= NUM_BUCKETS) begin
        o.status = ST_LARGE;
      end else if (b <= ob) begin
        // Shrinking or same class keeps the chunk in place.
        size_m[r.handle] = r.request_size;
        o.result_handle = r.handle;
        o.body_address = base_m[r.handle];
        o.size_class = 5'(ob);
      end else begin
        osz = size_m[r.handle];
        if (!take_chunk(b, r.request_size, d)) begin
          o.status = ST_OOM;
        end else begin
          give_back(r.handle);
          o.result_handle = d;
          o.body_address = base_m[d];
          o.size_class = 5'(b);
          o.moved = 1'b1;
          o.copy_length = (osz < r.request_size) ? osz : r.request_size;
        end
      end
    end
    return o;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  // Field by field comparison with the oldest prediction.
  task automatic compare_rsp(input rsp_t got);
    rsp_t w;
    if (want_q.size() == 0) begin
      report_mismatch("unexpected response", 32'(got.status), 32'hffff_ffff);
      return;
    end
    w = want_q.pop_front();
    if (got.status != w.status)
      report_mismatch("status", 32'(got.status), 32'(w.status));
    if (got.result_handle != w.result_handle)
      report_mismatch("result_handle", 32'(got.result_handle), 32'(w.result_handle));
    if (got.body_address != w.body_address)
      report_mismatch("body_address", got.body_address, w.body_address);
    if (got.size_class != w.size_class)
      report_mismatch("size_class", 32'(got.size_class), 32'(w.size_class));
    if (got.moved != w.moved)
      report_mismatch("moved", 32'(got.moved), 32'(w.moved));
    if (got.copy_length != w.copy_length)
      report_mismatch("copy_length", 32'(got.copy_length), 32'(w.copy_length));
    if (got.zero_fill != w.zero_fill)
      report_mismatch("zero_fill", 32'(got.zero_fill), 32'(w.zero_fill));
  endtask

  initial begin
    fail_count = 0;
  end

  // Track every handshake at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      overhead_m <= 7'd24;
      limit_m <= 32'hffff_ffff;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_ok_m[i] = 1'b0;
        head_m[i] = '0;
      end
      desc_top_m = 0;
      pool_top_m = '0;
      want_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEAP_LIMIT) limit_m <= pwdata;
        else overhead_m <= pwdata[6:0];
      end
      // A response never belongs to the request accepted at the same edge.
      if (rsp_valid && !rsp_stall) compare_rsp(rsp);
      if (req_valid && !req_stall) want_q.push_back(alloc_response(req));
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the size class free list allocator.
// Directed requests cover the size extremes, every request kind, bad handles,
// too-large sizes and double frees; random phases under several register settings
// follow, with random idle bursts on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import scfl_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          fail_count;

  // Idle control for the two sides (quiet is shared) and the top handle.
  bit          quiet;
  bit          start_hold;
  int          hold_left;
  int          stall_left;
  logic [9:0]  top_handle;

  size_class_free_list_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  scfl_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .pending(pending), .fail_count(fail_count)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stall bursts plus one long hold-off.
  always @(negedge clk) begin
    if (start_hold) begin
      start_hold = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall = 1'b1;
    end else if (quiet) begin
      rsp_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall = 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      rsp_stall = 1'b1;
    end else begin
      rsp_stall = 1'b0;
    end
  end

  // Highest handle granted so far steers the random handles.
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.result_handle > top_handle)
      top_handle <= rsp.result_handle;
  end

  // Offer one request and hold it until accepted.
  task automatic send_req(input req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic send_kind(input kind_t k, input logic [25:0] sz,
                           input logic [15:0] cnt, input logic [9:0] h);
    req_t r;
    r.kind = k;
    r.request_size = sz;
    r.element_count = cnt;
    r.handle = h;
    send_req(r);
  endtask

  // Register write with a setup phase and then an access phase.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Wait for every response and the tail of any refill.
  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Random request, mostly small sizes so descriptors last.
  function automatic req_t random_req();
    req_t r;
    int   sh;
    int   pick;
    pick = $urandom_range(0, 99);
    r.kind = (pick < 35) ? KIND_ALLOC : (pick < 50) ? KIND_CALLOC :
             (pick < 70) ? KIND_REALLOC : KIND_FREE;
    sh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 26) : $urandom_range(0, 10);
    if (sh == 26)
      r.request_size = ($urandom_range(0, 2) == 0) ? 26'd33554432 :
                       26'($urandom_range(16777216, 33554432));
    else
      r.request_size = 26'($urandom & ((32'd1 << sh) - 1));
    r.element_count = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    pick = $urandom_range(0, 9);
    r.handle = (pick < 8) ? 10'($urandom_range(0, top_handle)) :
               (pick == 8) ? 10'($urandom) : 10'd1023;
    return r;
  endfunction

  // Main stimulus.
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    start_hold = 1'b0;
    hold_left = 0;
    stall_left = 0;
    top_handle = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset settings.
    send_kind(KIND_ALLOC, 26'd0, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd1, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd8, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd9, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd16777216, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd16777217, 16'd0, 10'd0);
    send_kind(KIND_ALLOC, 26'd33554432, 16'd0, 10'd0);
    send_kind(KIND_CALLOC, 26'd0, 16'd0, 10'd0);
    send_kind(KIND_CALLOC, 26'd4096, 16'd4096, 10'd0);
    send_kind(KIND_CALLOC, 26'd33554432, 16'd65535, 10'd0);
    send_kind(KIND_FREE, 26'd0, 16'd0, 10'd0);
    send_kind(KIND_FREE, 26'd0, 16'd0, 10'd0);
    send_kind(KIND_FREE, 26'd0, 16'd0, 10'd1023);
    send_kind(KIND_REALLOC, 26'd4, 16'd0, 10'd1);
    send_kind(KIND_REALLOC, 26'd1000, 16'd0, 10'd1);
    send_kind(KIND_REALLOC, 26'd20, 16'd0, 10'd1);
    send_kind(KIND_REALLOC, 26'd33554432, 16'd0, 10'd2);
    send_kind(KIND_REALLOC, 26'd8, 16'd0, 10'd1023);
    send_kind(KIND_FREE, 26'd0, 16'd0, 10'd0);
    send_kind(KIND_FREE, 26'd0, 16'd0, 10'd2);
    drain();

    // Random phases under several register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_CHUNK_OVERHEAD, 32'd0);
          write_reg(REG_HEAP_LIMIT, 32'hffff_ffff);
        end
        2: begin
          write_reg(REG_CHUNK_OVERHEAD, 32'd64);
          write_reg(REG_HEAP_LIMIT, 32'd0);
        end
        3: begin
          write_reg(REG_CHUNK_OVERHEAD, 32'($urandom_range(1, 63)));
          write_reg(REG_HEAP_LIMIT, 32'hffff_ffff);
        end
        default: ;
      endcase
      for (int i = 0; i < 400; i++) begin
        if (phase == 1 && i == 50) start_hold = 1'b1;
        if (phase == 3 && i == 200) quiet = 1'b1;
        send_req(random_req());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/scfl_pkg.sv
rtl/scfl_ram.sv
rtl/scfl_front.sv
rtl/scfl_queue.sv
rtl/scfl_back.sv
rtl/size_class_free_list_allocator_top.sv
tb/scfl_checker.sv
tb/tb.sv
